// ===== rtl/ehc_pkg.sv =====
// shared constants and elaboration-time table functions for the coordinate converter
package ehc_pkg;

  // default widths
  localparam int ANGLE_BITS_DEF    = 32;
  localparam int CORDIC_STAGES_DEF = 28;

  // operation codes
  localparam logic OP_EQU_TO_HOR = 1'b0;
  localparam logic OP_HOR_TO_EQU = 1'b1;

  // 1/(2pi) as a 64-bit fraction
  localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;

  // (a*b) >> s, truncated to 64 bits
  function automatic logic [63:0] mulu_shift(input logic [63:0] a, input logic [63:0] b,
                                             input int s);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    prod = prod >> s;
    return prod[63:0];
  endfunction

  // arctangent of 2^-idx as a binary angle of ab bits
  function automatic logic [63:0] atan_entry(input int idx, input int ab);
    logic [63:0]  sum;
    logic [63:0]  term;
    logic [63:0]  hi;
    logic [127:0] prod;
    int           k;
    int           e;
    logic         done;
    sum  = 64'd0;
    done = 1'b0;
    if (idx == 0) begin
      return 64'd1 << (ab - 3);
    end
    // series for atan in radians, 62 fraction bits
    for (k = 0; k < 32; k++) begin
      e = idx * (2 * k + 1);
      if (!done && e <= 62) begin
        term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
        if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end else begin
        done = 1'b1;
      end
    end
    prod = {64'd0, sum} * {64'd0, INV_TWO_PI_Q64};
    hi   = prod[127:64];
    return (hi + (64'd1 << (61 - ab))) >> (62 - ab);
  endfunction

  // inverse cordic gain with ab-2 fraction bits
  function automatic logic [63:0] inv_gain_val(input int ab, input int n);
    logic [63:0] p;
    logic [63:0] y;
    logic [63:0] t;
    logic [63:0] three;
    int          i;
    int          k;
    p = 64'd1 << 60;
    for (i = 0; i < n; i++) begin
      if (2 * i < 64) begin
        p = p + (p >> (2 * i));
      end
    end
    three = 64'd3 << 60;
    y     = three / 64'd5;
    // newton steps towards 1/sqrt(p)
    for (k = 0; k < 8; k++) begin
      t = mulu_shift(y, y, 60);
      t = mulu_shift(p, t, 60);
      if (t > three) begin
        t = three;
      end
      y = mulu_shift(y, three - t, 60) >> 1;
    end
    return (y + (64'd1 << (61 - ab))) >> (62 - ab);
  endfunction

endpackage

// ===== rtl/ehc_mulf.sv =====
// fixed-point product rounded half up on magnitude, sign applied after
module ehc_mulf #(
  parameter int W  = 34,
  parameter int FB = 30
) (
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  output logic signed [W-1:0] p
);

  logic [W-1:0]   ua;
  logic [W-1:0]   ub;
  logic [2*W-1:0] prod;
  logic [2*W-1:0] rnd;
  logic [W-1:0]   mag;
  logic           neg;

  // magnitudes, product and rounding
  always_comb begin
    neg  = a[W-1] ^ b[W-1];
    ua   = a[W-1] ? W'(-a) : W'(a);
    ub   = b[W-1] ? W'(-b) : W'(b);
    prod = {{W{1'b0}}, ua} * {{W{1'b0}}, ub};
    rnd  = prod + ((2*W)'(1) << (FB - 1));
    mag  = W'(rnd >> FB);
    p    = neg ? -$signed(mag) : $signed(mag);
  end

endmodule

// ===== rtl/ehc_rot_cell.sv =====
// one rotation-mode cordic micro-rotation with its stage register
module ehc_rot_cell #(
  parameter int AB    = 32,
  parameter int STAGE = 0
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [AB+1:0] x_i,
  input  logic signed [AB+1:0] y_i,
  input  logic signed [AB:0]   z_i,
  output logic signed [AB+1:0] x_o,
  output logic signed [AB+1:0] y_o,
  output logic signed [AB:0]   z_o
);
  import ehc_pkg::*;

  localparam logic signed [AB:0] ATAN = (AB+1)'(atan_entry(STAGE, AB));

  logic signed [AB+1:0] x_nxt;
  logic signed [AB+1:0] y_nxt;
  logic signed [AB:0]   z_nxt;
  logic signed [AB+1:0] x_r;
  logic signed [AB+1:0] y_r;
  logic signed [AB:0]   z_r;

  // rotate towards zero residual angle
  always_comb begin
    if (!z_i[AB]) begin
      x_nxt = x_i - (y_i >>> STAGE);
      y_nxt = y_i + (x_i >>> STAGE);
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + (y_i >>> STAGE);
      y_nxt = y_i - (x_i >>> STAGE);
      z_nxt = z_i + ATAN;
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

// ===== rtl/ehc_vec_cell.sv =====
// one vectoring-mode cordic micro-rotation with its stage register and side data
module ehc_vec_cell #(
  parameter int AB    = 32,
  parameter int STAGE = 0,
  parameter int AUX_W = 1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AB+1:0] x_i,
  input  logic signed [AB+1:0] y_i,
  input  logic signed [AB:0]   z_i,
  input  logic [AUX_W-1:0]     aux_i,
  output logic signed [AB+1:0] x_o,
  output logic signed [AB+1:0] y_o,
  output logic signed [AB:0]   z_o,
  output logic [AUX_W-1:0]     aux_o
);
  import ehc_pkg::*;

  localparam logic signed [AB:0] ATAN = (AB+1)'(atan_entry(STAGE, AB));

  logic signed [AB+1:0] x_nxt;
  logic signed [AB+1:0] y_nxt;
  logic signed [AB:0]   z_nxt;
  logic signed [AB+1:0] x_r;
  logic signed [AB+1:0] y_r;
  logic signed [AB:0]   z_r;
  logic [AUX_W-1:0]     aux_r;

  // drive the vertical part towards zero, accumulating angle
  always_comb begin
    if (y_i[AB+1]) begin
      x_nxt = x_i - (y_i >>> STAGE);
      y_nxt = y_i + (x_i >>> STAGE);
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + (y_i >>> STAGE);
      y_nxt = y_i - (x_i >>> STAGE);
      z_nxt = z_i + ATAN;
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      aux_r <= aux_i;
    end
  end

  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;
  assign aux_o = aux_r;

endmodule

// ===== rtl/equatorial_horizontal_convert_unit.sv =====
// top level of the equatorial / horizontal coordinate converter
//
//  channel   ports                                       direction
//  input     in_valid/in_ready, opcode, polar, azimuth   into block
//  result    out_valid/out_ready, polar, azimuth         out of block
//  config    cfg_psel/penable/pwrite/paddr/pwdata/prdata write/read latitude
//
// one transaction enters per cycle while the pipeline is not stalled; the pipeline is built from
// three chains of cordic cells (sin/cos, then two vectoring passes) plus six
// registers for input, two product stages, magnitude and two pre-rotations.
// reset clears all stage valid bits and the latitude register to zero.
// each stage holds while the one after it is full and stalled, so bubbles close up.
module equatorial_horizontal_convert_unit #(
  parameter int ANGLE_BITS    = ehc_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = ehc_pkg::CORDIC_STAGES_DEF,
  parameter int DATA_W        = (ANGLE_BITS > 32) ? 64 : 32,
  parameter int ADDR_W        = (ANGLE_BITS > 32) ? 4 : 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_opcode,
  input  logic signed [ANGLE_BITS-1:0] in_polar_angle_in,
  input  logic [ANGLE_BITS-1:0]        in_azimuthal_angle_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [ANGLE_BITS-1:0] out_polar_angle_out,
  output logic [ANGLE_BITS-1:0]        out_azimuthal_angle_out,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [ADDR_W-1:0]            cfg_paddr,
  input  logic [DATA_W-1:0]            cfg_pwdata,
  output logic [DATA_W-1:0]            cfg_prdata,
  output logic                         cfg_pready
);
  import ehc_pkg::*;

  localparam int AB = ANGLE_BITS;
  localparam int N  = CORDIC_STAGES;
  localparam int W  = AB + 2;
  localparam int ZW = AB + 1;
  localparam int FB = AB - 2;
  localparam int NS = 3 * N + 6;
  localparam int S_P1   = N + 1;
  localparam int S_P2   = N + 2;
  localparam int S_V1   = N + 3;
  localparam int S_MAG  = 2 * N + 4;
  localparam int S_V2   = 2 * N + 5;

  localparam logic signed [W-1:0]  IG      = W'(inv_gain_val(AB, N));
  localparam logic signed [ZW-1:0] QUARTER = ZW'(1) <<< (AB - 2);
  localparam logic signed [ZW-1:0] HALF    = ZW'(1) <<< (AB - 1);

  // configuration register
  logic [AB-1:0] lat_r;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r <= '0;
    end else if (cfg_wr && !cfg_paddr[ADDR_W-1]) begin
      lat_r <= cfg_pwdata[AB-1:0];
    end
  end

  assign cfg_prdata = cfg_paddr[ADDR_W-1] ? '0 : DATA_W'($signed(lat_r));

  // stage valid bits and ready chain
  logic [NS-1:0] v_r;
  logic [NS-1:0] rdy;

  genvar s;
  generate
    for (s = 0; s < NS; s++) begin : g_flow
      if (s == NS - 1) begin : g_last
        assign rdy[s] = !v_r[s] || out_ready;
      end else begin : g_mid
        assign rdy[s] = !v_r[s] || rdy[s+1];
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s] <= 1'b0;
        end else if (rdy[s]) begin
          v_r[s] <= (s == 0) ? in_valid : v_r[(s == 0) ? 0 : s-1];
        end
      end
    end
  endgenerate

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];

  // input stage: fold each angle into the right half plane
  logic [AB-1:0]          ang [3];
  logic signed [ZW-1:0]   fz  [3];
  logic [2:0]             fneg;
  logic signed [ZW-1:0]   rz0_r [3];
  logic                   op_sr_r  [N+1];
  logic [2:0]             neg_sr_r [N+1];

  assign ang[0] = in_polar_angle_in;
  assign ang[1] = in_azimuthal_angle_in;
  assign ang[2] = lat_r;

  genvar l;
  generate
    for (l = 0; l < 3; l++) begin : g_fold
      logic signed [ZW-1:0] za;
      assign za = $signed({ang[l][AB-1], ang[l]});
      always_comb begin
        if (za > QUARTER) begin
          fz[l]   = za - HALF;
          fneg[l] = 1'b1;
        end else if (za < -QUARTER) begin
          fz[l]   = za + HALF;
          fneg[l] = 1'b1;
        end else begin
          fz[l]   = za;
          fneg[l] = 1'b0;
        end
      end
      always_ff @(posedge clk) begin
        if (rdy[0]) begin
          rz0_r[l] <= fz[l];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      op_sr_r[0]  <= in_opcode;
      neg_sr_r[0] <= fneg;
    end
  end

  // sine/cosine chains, three lanes side by side
  logic signed [W-1:0]  rx [3][N+1];
  logic signed [W-1:0]  ry [3][N+1];
  logic signed [ZW-1:0] rz [3][N+1];

  genvar k;
  generate
    for (l = 0; l < 3; l++) begin : g_lane
      assign rx[l][0] = IG;
      assign ry[l][0] = '0;
      assign rz[l][0] = rz0_r[l];
      for (k = 0; k < N; k++) begin : g_rot
        ehc_rot_cell #(.AB(AB), .STAGE(k)) u_cell (
          .clk (clk),
          .en  (rdy[k+1]),
          .x_i (rx[l][k]),
          .y_i (ry[l][k]),
          .z_i (rz[l][k]),
          .x_o (rx[l][k+1]),
          .y_o (ry[l][k+1]),
          .z_o (rz[l][k+1])
        );
      end
    end
    for (k = 0; k < N; k++) begin : g_side
      always_ff @(posedge clk) begin
        if (rdy[k+1]) begin
          op_sr_r[k+1]  <= op_sr_r[k];
          neg_sr_r[k+1] <= neg_sr_r[k];
        end
      end
    end
  endgenerate

  // undo the half-turn fold
  logic signed [W-1:0] sv [3];
  logic signed [W-1:0] cv [3];

  generate
    for (l = 0; l < 3; l++) begin : g_sign
      assign sv[l] = neg_sr_r[N][l] ? -ry[l][N] : ry[l][N];
      assign cv[l] = neg_sr_r[N][l] ? -rx[l][N] : rx[l][N];
    end
  endgenerate

  // first product stage
  logic signed [W-1:0] m_cc, m_clsp, m_slsp, m_sacp;
  logic signed [W-1:0] cc_r, clsp_r, slsp_r, sacp_r, sl_r, cl_r;
  logic                op_p1_r;

  ehc_mulf #(.W(W), .FB(FB)) u_m_cc   (.a(cv[0]), .b(cv[1]), .p(m_cc));
  ehc_mulf #(.W(W), .FB(FB)) u_m_clsp (.a(cv[2]), .b(sv[0]), .p(m_clsp));
  ehc_mulf #(.W(W), .FB(FB)) u_m_slsp (.a(sv[2]), .b(sv[0]), .p(m_slsp));
  ehc_mulf #(.W(W), .FB(FB)) u_m_sacp (.a(sv[1]), .b(cv[0]), .p(m_sacp));

  always_ff @(posedge clk) begin
    if (rdy[S_P1]) begin
      cc_r    <= m_cc;
      clsp_r  <= m_clsp;
      slsp_r  <= m_slsp;
      sacp_r  <= m_sacp;
      sl_r    <= sv[2];
      cl_r    <= cv[2];
      op_p1_r <= op_sr_r[N];
    end
  end

  // second product stage and the rotated vector
  logic signed [W-1:0] m_slcc, m_clcc;
  logic signed [W-1:0] vx_nxt, vy_nxt, vz_nxt;
  logic signed [W-1:0] vx_r, vy_r, vz_r;

  ehc_mulf #(.W(W), .FB(FB)) u_m_slcc (.a(sl_r), .b(cc_r), .p(m_slcc));
  ehc_mulf #(.W(W), .FB(FB)) u_m_clcc (.a(cl_r), .b(cc_r), .p(m_clcc));

  always_comb begin
    if (op_p1_r == OP_HOR_TO_EQU) begin
      vx_nxt = clsp_r + m_slcc;
      vy_nxt = sacp_r;
      vz_nxt = slsp_r - m_clcc;
    end else begin
      vx_nxt = clsp_r - m_slcc;
      vy_nxt = -sacp_r;
      vz_nxt = slsp_r + m_clcc;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_P2]) begin
      vx_r <= vx_nxt;
      vy_r <= vy_nxt;
      vz_r <= vz_nxt;
    end
  end

  // pre-rotation for the azimuth pass
  logic signed [W-1:0]  ax [N+1];
  logic signed [W-1:0]  ay [N+1];
  logic signed [ZW-1:0] az [N+1];
  logic [W:0]           aa [N+1];
  logic signed [W-1:0]  p1x_r, p1y_r;
  logic signed [ZW-1:0] p1z_r;
  logic [W:0]           p1a_r;

  always_ff @(posedge clk) begin
    if (rdy[S_V1]) begin
      p1a_r <= {(vx_r == '0) && (vy_r == '0), vz_r};
      if (vx_r[W-1]) begin
        p1x_r <= -vx_r;
        p1y_r <= -vy_r;
        p1z_r <= HALF;
      end else begin
        p1x_r <= vx_r;
        p1y_r <= vy_r;
        p1z_r <= '0;
      end
    end
  end

  assign ax[0] = p1x_r;
  assign ay[0] = p1y_r;
  assign az[0] = p1z_r;
  assign aa[0] = p1a_r;

  generate
    for (k = 0; k < N; k++) begin : g_vec1
      ehc_vec_cell #(.AB(AB), .STAGE(k), .AUX_W(W + 1)) u_cell (
        .clk   (clk),
        .en    (rdy[S_V1+1+k]),
        .x_i   (ax[k]),
        .y_i   (ay[k]),
        .z_i   (az[k]),
        .aux_i (aa[k]),
        .x_o   (ax[k+1]),
        .y_o   (ay[k+1]),
        .z_o   (az[k+1]),
        .aux_o (aa[k+1])
      );
    end
  endgenerate

  // gain-corrected horizontal magnitude
  logic signed [W-1:0] m_mag;
  logic signed [W-1:0] mag_r, vz2_r;
  logic [AB-1:0]       azi_r;
  logic                zero1;

  assign zero1 = aa[N][W];

  ehc_mulf #(.W(W), .FB(FB)) u_m_mag (.a(ax[N]), .b(IG), .p(m_mag));

  always_ff @(posedge clk) begin
    if (rdy[S_MAG]) begin
      mag_r <= zero1 ? '0 : m_mag;
      azi_r <= zero1 ? '0 : az[N][AB-1:0];
      vz2_r <= aa[N][W-1:0];
    end
  end

  // pre-rotation for the polar pass
  logic signed [W-1:0]  bx [N+1];
  logic signed [W-1:0]  by [N+1];
  logic signed [ZW-1:0] bz [N+1];
  logic [AB:0]          ba [N+1];
  logic signed [W-1:0]  p2x_r, p2y_r;
  logic signed [ZW-1:0] p2z_r;
  logic [AB:0]          p2a_r;

  always_ff @(posedge clk) begin
    if (rdy[S_V2]) begin
      p2a_r <= {(mag_r == '0) && (vz2_r == '0), azi_r};
      if (mag_r[W-1]) begin
        p2x_r <= -mag_r;
        p2y_r <= -vz2_r;
        p2z_r <= HALF;
      end else begin
        p2x_r <= mag_r;
        p2y_r <= vz2_r;
        p2z_r <= '0;
      end
    end
  end

  assign bx[0] = p2x_r;
  assign by[0] = p2y_r;
  assign bz[0] = p2z_r;
  assign ba[0] = p2a_r;

  generate
    for (k = 0; k < N; k++) begin : g_vec2
      ehc_vec_cell #(.AB(AB), .STAGE(k), .AUX_W(AB + 1)) u_cell (
        .clk   (clk),
        .en    (rdy[S_V2+1+k]),
        .x_i   (bx[k]),
        .y_i   (by[k]),
        .z_i   (bz[k]),
        .aux_i (ba[k]),
        .x_o   (bx[k+1]),
        .y_o   (by[k+1]),
        .z_o   (bz[k+1]),
        .aux_o (ba[k+1])
      );
    end
  endgenerate

  // result transaction from the last cell
  assign out_polar_angle_out     = ba[N][AB] ? '0 : $signed(bz[N][AB-1:0]);
  assign out_azimuthal_angle_out = ba[N][AB-1:0];

endmodule
